### hw/rtl/tswqa_pkg.sv
`default_nettype none
package tswqa_pkg;

  // Grant limit per dispatch request, and the width of a grant count up to it.
  localparam int MAX_GRANTS = 16;
  localparam int GRANT_W    = $clog2(MAX_GRANTS + 1);

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int CREDIT_W = 3;
  localparam int COUNT_W  = 16;

  // Command codes.
  localparam logic CMD_TEMP     = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  // Queue codes.
  localparam logic QUEUE_FAST   = 1'b0;
  localparam logic QUEUE_NORMAL = 1'b1;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZONE_FILTER = 3'd0,
    REG_GUARD_NS    = 3'd1,
    REG_RISE_WARM   = 3'd2,
    REG_RISE_HOT    = 3'd3,
    REG_RISE_CRIT   = 3'd4,
    REG_FALL_COOL   = 3'd5,
    REG_FALL_WARM   = 3'd6,
    REG_FALL_HOT    = 3'd7
  } cfg_reg_t;

  // Thermal stages.
  typedef enum logic [1:0] {
    STAGE_COOL = 2'd0,
    STAGE_WARM = 2'd1,
    STAGE_HOT  = 2'd2,
    STAGE_CRIT = 2'd3
  } stage_t;

  // Register reset values.
  localparam logic signed [8:0] RST_ZONE_FILTER = -9'sd1;
  localparam logic [63:0]       RST_GUARD_NS    = 64'd5000000000;
  localparam logic signed [8:0] RST_RISE_WARM   = 9'sd67;
  localparam logic signed [8:0] RST_RISE_HOT    = 9'sd72;
  localparam logic signed [8:0] RST_RISE_CRIT   = 9'sd77;
  localparam logic signed [8:0] RST_FALL_COOL   = 9'sd64;
  localparam logic signed [8:0] RST_FALL_WARM   = 9'sd69;
  localparam logic signed [8:0] RST_FALL_HOT    = 9'sd74;

  typedef struct packed {
    logic signed [8:0] zone_filter;
    logic [63:0]       guard_ns;
    logic signed [8:0] rise_warm_c;
    logic signed [8:0] rise_hot_c;
    logic signed [8:0] rise_crit_c;
    logic signed [8:0] fall_cool_c;
    logic signed [8:0] fall_warm_c;
    logic signed [8:0] fall_hot_c;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic       granted;
    logic       queue_sel;
    logic       forced;
    logic [1:0] stage_now;
    logic       last;
  } result_t;

  // Operands of one arbitration step.
  typedef struct packed {
    logic [CREDIT_W-1:0] credit_fast;
    logic [CREDIT_W-1:0] credit_normal;
    logic [COUNT_W-1:0]  fast_cnt;
    logic [COUNT_W-1:0]  normal_cnt;
    stage_t              stage;
    logic                force_first;
  } step_in_t;

  // Outcome of one arbitration step.
  typedef struct packed {
    logic                grant;
    logic                queue;
    logic                forced;
    logic [CREDIT_W-1:0] credit_fast;
    logic [CREDIT_W-1:0] credit_normal;
    logic [COUNT_W-1:0]  fast_cnt;
    logic [COUNT_W-1:0]  normal_cnt;
  } step_out_t;

  // Credit reload ratio of the fast queue per stage.
  function automatic logic [CREDIT_W-1:0] ratio_fast(stage_t s);
    case (s)
      STAGE_COOL: return 3'd5;
      STAGE_WARM: return 3'd7;
      STAGE_HOT:  return 3'd3;
      default:    return 3'd1;
    endcase
  endfunction

  // Credit reload ratio of the normal queue per stage.
  function automatic logic [CREDIT_W-1:0] ratio_normal(stage_t s);
    case (s)
      STAGE_COOL: return 3'd3;
      STAGE_WARM: return 3'd3;
      STAGE_HOT:  return 3'd1;
      default:    return 3'd0;
    endcase
  endfunction

  // Burst cap of a stage, limited by the overall grant limit.
  function automatic logic [GRANT_W-1:0] grant_cap(stage_t s);
    logic [6:0] c;
    case (s)
      STAGE_COOL: c = 7'd16;
      STAGE_WARM: c = 7'd8;
      STAGE_HOT:  c = 7'd4;
      default:    c = 7'd2;
    endcase
    if (c > 7'(MAX_GRANTS)) return GRANT_W'(MAX_GRANTS);
    return GRANT_W'(c);
  endfunction

  // Threshold in whole degrees scaled to millidegrees.
  function automatic logic signed [31:0] thr_mc(logic signed [8:0] deg);
    logic signed [31:0] wide;
    wide = 32'(deg);
    return wide * 32'sd1000;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/tswqa_in_if.sv
`default_nettype none
interface tswqa_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [7:0]         zone_id;
  logic signed [31:0] temp_mc;
  logic [15:0]        free_slots;
  logic [15:0]        fast_count;
  logic [15:0]        normal_count;
  logic [63:0]        time_ns;

  modport source (
    output valid, cmd, zone_id, temp_mc, free_slots, fast_count, normal_count, time_ns,
    input  ready
  );
  modport sink (
    input  valid, cmd, zone_id, temp_mc, free_slots, fast_count, normal_count, time_ns,
    output ready
  );
endinterface
`default_nettype wire

### hw/rtl/tswqa_out_if.sv
`default_nettype none
interface tswqa_out_if;
  logic       valid;
  logic       ready;
  logic       granted;
  logic       queue_sel;
  logic       forced;
  logic [1:0] stage_now;
  logic       last;

  modport source (
    output valid, granted, queue_sel, forced, stage_now, last,
    input  ready
  );
  modport sink (
    input  valid, granted, queue_sel, forced, stage_now, last,
    output ready
  );
endinterface
`default_nettype wire

### hw/rtl/tswqa_cfg_regs.sv
`default_nettype none
module tswqa_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tswqa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tswqa_pkg::CFG_DATA_W-1:0] cfg_data,
  output tswqa_pkg::cfg_t                  cfg
);
  import tswqa_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index and truncate the data to the register width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_ZONE_FILTER: cfg_nxt.zone_filter = cfg_data[8:0];
        REG_GUARD_NS:    cfg_nxt.guard_ns    = cfg_data;
        REG_RISE_WARM:   cfg_nxt.rise_warm_c = cfg_data[8:0];
        REG_RISE_HOT:    cfg_nxt.rise_hot_c  = cfg_data[8:0];
        REG_RISE_CRIT:   cfg_nxt.rise_crit_c = cfg_data[8:0];
        REG_FALL_COOL:   cfg_nxt.fall_cool_c = cfg_data[8:0];
        REG_FALL_WARM:   cfg_nxt.fall_warm_c = cfg_data[8:0];
        REG_FALL_HOT:    cfg_nxt.fall_hot_c  = cfg_data[8:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zone_filter <= RST_ZONE_FILTER;
      cfg_r.guard_ns    <= RST_GUARD_NS;
      cfg_r.rise_warm_c <= RST_RISE_WARM;
      cfg_r.rise_hot_c  <= RST_RISE_HOT;
      cfg_r.rise_crit_c <= RST_RISE_CRIT;
      cfg_r.fall_cool_c <= RST_FALL_COOL;
      cfg_r.fall_warm_c <= RST_FALL_WARM;
      cfg_r.fall_hot_c  <= RST_FALL_HOT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### hw/rtl/tswqa_thermal.sv
`default_nettype none
module tswqa_thermal (
  input  tswqa_pkg::cfg_t   cfg,
  input  tswqa_pkg::stage_t stage,
  input  logic [7:0]        zone_id,
  input  logic signed [31:0] temp_mc,
  output logic              zone_ok,
  output tswqa_pkg::stage_t stage_next
);
  import tswqa_pkg::*;

  // A negative filter accepts every zone.
  assign zone_ok = cfg.zone_filter[8] || (cfg.zone_filter[7:0] == zone_id);

  // Move at most one level, with separate rising and falling thresholds.
  always_comb begin
    case (stage)
      STAGE_COOL: begin
        stage_next = (temp_mc >= thr_mc(cfg.rise_warm_c)) ? STAGE_WARM : STAGE_COOL;
      end
      STAGE_WARM: begin
        if (temp_mc >= thr_mc(cfg.rise_hot_c)) begin
          stage_next = STAGE_HOT;
        end else if (temp_mc < thr_mc(cfg.fall_cool_c)) begin
          stage_next = STAGE_COOL;
        end else begin
          stage_next = STAGE_WARM;
        end
      end
      STAGE_HOT: begin
        if (temp_mc >= thr_mc(cfg.rise_crit_c)) begin
          stage_next = STAGE_CRIT;
        end else if (temp_mc < thr_mc(cfg.fall_warm_c)) begin
          stage_next = STAGE_WARM;
        end else begin
          stage_next = STAGE_HOT;
        end
      end
      default: begin
        stage_next = (temp_mc < thr_mc(cfg.fall_hot_c)) ? STAGE_HOT : STAGE_CRIT;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/tswqa_credit_unit.sv
`default_nettype none
module tswqa_credit_unit (
  input  tswqa_pkg::step_in_t  step_in,
  output tswqa_pkg::step_out_t step_out
);
  import tswqa_pkg::*;

  logic [CREDIT_W-1:0] cf;
  logic [CREDIT_W-1:0] cn;
  logic                q_pref;
  logic                q_try;
  logic                pref_ok;
  logic                try_ok;

  always_comb begin
    // Reload both credits from the stage ratio once both are spent.
    if (step_in.credit_fast == '0 && step_in.credit_normal == '0) begin
      cf = ratio_fast(step_in.stage);
      cn = ratio_normal(step_in.stage);
    end else begin
      cf = step_in.credit_fast;
      cn = step_in.credit_normal;
    end

    // Prefer the queue with more credit (the fast queue on a tie), fall back to the other one.
    q_pref  = (cf >= cn) ? QUEUE_FAST : QUEUE_NORMAL;
    pref_ok = (q_pref == QUEUE_NORMAL) ? (cn != '0 && step_in.normal_cnt != '0)
                                       : (cf != '0 && step_in.fast_cnt != '0);
    q_try   = pref_ok ? q_pref : ~q_pref;
    try_ok  = (q_try == QUEUE_NORMAL) ? (cn != '0 && step_in.normal_cnt != '0)
                                      : (cf != '0 && step_in.fast_cnt != '0);

    step_out.credit_fast   = cf;
    step_out.credit_normal = cn;
    step_out.fast_cnt      = step_in.fast_cnt;
    step_out.normal_cnt    = step_in.normal_cnt;
    step_out.forced        = 1'b0;
    step_out.queue         = QUEUE_FAST;
    step_out.grant         = 1'b0;

    if (step_in.force_first && step_in.normal_cnt != '0) begin
      // Starvation guard: serve the normal queue, take a credit if one is left.
      step_out.grant      = 1'b1;
      step_out.forced     = 1'b1;
      step_out.queue      = QUEUE_NORMAL;
      step_out.normal_cnt = step_in.normal_cnt - COUNT_W'(1);
      if (cn != '0) begin
        step_out.credit_normal = cn - CREDIT_W'(1);
      end
    end else if (try_ok) begin
      step_out.grant = 1'b1;
      step_out.queue = q_try;
      if (q_try == QUEUE_NORMAL) begin
        step_out.normal_cnt    = step_in.normal_cnt - COUNT_W'(1);
        step_out.credit_normal = cn - CREDIT_W'(1);
      end else begin
        step_out.fast_cnt    = step_in.fast_cnt - COUNT_W'(1);
        step_out.credit_fast = cf - CREDIT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/thermal_staged_weighted_queue_arbiter.sv
// Temperature event: the accepted request moves to the event step, which loads the result
// and returns to idle, where the next request can be taken.
// Dispatch request: one setup step, one arbitration step per grant, one step that ends the
// burst and one closing step, which loads the final result and returns to idle, where the
// next request is taken. Output stalls hold the event, grant and closing steps.
// Reset (rst_n low, synchronous): cool stage, credits zero, defaults.
`default_nettype none
module thermal_staged_weighted_queue_arbiter (
  input  logic                             clk,
  input  logic                             rst_n,
  tswqa_in_if.sink                         in_ch,
  tswqa_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [tswqa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tswqa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tswqa_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVENT = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_GRANT = 5'b01000,
    ST_FLUSH = 5'b10000
  } seq_state_t;

  cfg_t       cfg;
  seq_state_t state_r, state_nxt;
  stage_t     stage_r, stage_nxt;
  logic [CREDIT_W-1:0] cf_r, cf_nxt;
  logic [CREDIT_W-1:0] cn_r, cn_nxt;
  logic [63:0]         lnt_r, lnt_nxt;

  // Latched request.
  logic [7:0]          zone_r, zone_nxt;
  logic signed [31:0]  temp_r, temp_nxt;
  logic [COUNT_W-1:0]  slots_r, slots_nxt;
  logic [COUNT_W-1:0]  fcnt_r, fcnt_nxt;
  logic [COUNT_W-1:0]  ncnt_r, ncnt_nxt;
  logic [63:0]         time_r, time_nxt;

  // Dispatch progress.
  logic [GRANT_W-1:0]  budget_r, budget_nxt;
  logic [GRANT_W-1:0]  n_r, n_nxt;
  logic                force_r, force_nxt;
  result_t             pend_r, pend_nxt;
  logic                pend_v_r, pend_v_nxt;

  // Output register.
  result_t             out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_load;
  logic                adv;

  logic                zone_ok;
  stage_t              stage_next;
  stage_t              ev_stage;
  step_in_t            step_in;
  step_out_t           step_out;
  logic [63:0]         waited;
  logic [GRANT_W-1:0]  cap;

  tswqa_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  tswqa_thermal u_thermal (
    .cfg        (cfg),
    .stage      (stage_r),
    .zone_id    (zone_r),
    .temp_mc    (temp_r),
    .zone_ok    (zone_ok),
    .stage_next (stage_next)
  );

  // The step unit works on the live credits and working counts.
  assign step_in.credit_fast   = cf_r;
  assign step_in.credit_normal = cn_r;
  assign step_in.fast_cnt      = fcnt_r;
  assign step_in.normal_cnt    = ncnt_r;
  assign step_in.stage         = stage_r;
  assign step_in.force_first   = force_r && (n_r == '0);

  tswqa_credit_unit u_step (
    .step_in  (step_in),
    .step_out (step_out)
  );

  assign adv      = !out_valid_r || out_ch.ready;
  assign ev_stage = zone_ok ? stage_next : stage_r;
  assign waited   = time_r - lnt_r;
  assign cap      = grant_cap(stage_r);

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    stage_nxt  = stage_r;
    cf_nxt     = cf_r;
    cn_nxt     = cn_r;
    lnt_nxt    = lnt_r;
    zone_nxt   = zone_r;
    temp_nxt   = temp_r;
    slots_nxt  = slots_r;
    fcnt_nxt   = fcnt_r;
    ncnt_nxt   = ncnt_r;
    time_nxt   = time_r;
    budget_nxt = budget_r;
    n_nxt      = n_r;
    force_nxt  = force_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_nxt    = out_r;
    out_load   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          zone_nxt  = in_ch.zone_id;
          temp_nxt  = in_ch.temp_mc;
          slots_nxt = in_ch.free_slots;
          fcnt_nxt  = in_ch.fast_count;
          ncnt_nxt  = in_ch.normal_count;
          time_nxt  = in_ch.time_ns;
          state_nxt = (in_ch.cmd == CMD_DISPATCH) ? ST_SETUP : ST_EVENT;
        end
      end
      ST_EVENT: begin
        if (adv) begin
          if (ev_stage != stage_r) begin
            stage_nxt = ev_stage;
            cf_nxt    = '0;
            cn_nxt    = '0;
          end
          out_load          = 1'b1;
          out_nxt.granted   = 1'b0;
          out_nxt.queue_sel = QUEUE_FAST;
          out_nxt.forced    = 1'b0;
          out_nxt.stage_now = ev_stage;
          out_nxt.last      = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_SETUP: begin
        // Budget and starvation guard; no grants are given with zero free slots.
        if (slots_r == '0) begin
          budget_nxt = '0;
          force_nxt  = 1'b0;
        end else begin
          budget_nxt = (slots_r < COUNT_W'(cap)) ? slots_r[GRANT_W-1:0] : cap;
          force_nxt  = (ncnt_r != '0) && (waited >= cfg.guard_ns);
          if ((ncnt_r != '0) && (waited >= cfg.guard_ns)) begin
            lnt_nxt = time_r;
          end
        end
        n_nxt      = '0;
        pend_v_nxt = 1'b0;
        state_nxt  = ST_GRANT;
      end
      ST_GRANT: begin
        if (adv) begin
          if (n_r < budget_r) begin
            cf_nxt = step_out.credit_fast;
            cn_nxt = step_out.credit_normal;
            if (step_out.grant) begin
              fcnt_nxt = step_out.fast_cnt;
              ncnt_nxt = step_out.normal_cnt;
              // The held grant is known not to be the final one now.
              if (pend_v_r) begin
                out_load      = 1'b1;
                out_nxt       = pend_r;
                out_nxt.last  = 1'b0;
              end
              pend_nxt.granted   = 1'b1;
              pend_nxt.queue_sel = step_out.queue;
              pend_nxt.forced    = step_out.forced;
              pend_nxt.stage_now = stage_r;
              pend_nxt.last      = 1'b0;
              pend_v_nxt         = 1'b1;
              n_nxt              = n_r + GRANT_W'(1);
            end else begin
              state_nxt = ST_FLUSH;
            end
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        // Release the held grant as final, or a lone empty result.
        if (adv) begin
          out_load = 1'b1;
          if (pend_v_r) begin
            out_nxt = pend_r;
          end else begin
            out_nxt.granted   = 1'b0;
            out_nxt.queue_sel = QUEUE_FAST;
            out_nxt.forced    = 1'b0;
            out_nxt.stage_now = stage_r;
          end
          out_nxt.last = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stage_r     <= STAGE_COOL;
      cf_r        <= '0;
      cn_r        <= '0;
      lnt_r       <= '0;
      budget_r    <= '0;
      n_r         <= '0;
      force_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      cf_r        <= cf_nxt;
      cn_r        <= cn_nxt;
      lnt_r       <= lnt_nxt;
      budget_r    <= budget_nxt;
      n_r         <= n_nxt;
      force_r     <= force_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    zone_r  <= zone_nxt;
    temp_r  <= temp_nxt;
    slots_r <= slots_nxt;
    fcnt_r  <= fcnt_nxt;
    ncnt_r  <= ncnt_nxt;
    time_r  <= time_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.granted   = out_r.granted;
  assign out_ch.queue_sel = out_r.queue_sel;
  assign out_ch.forced    = out_r.forced;
  assign out_ch.stage_now = out_r.stage_now;
  assign out_ch.last      = out_r.last;

  // The grant count never passes the budget of the request.
  a_n_in_budget: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= budget_r)
    else $error("grant count exceeds budget");

  // An accepted request starts either an event or a dispatch.
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_SETUP || state_r == ST_EVENT))
    else $error("accepted request did not start");

  // The closing step always presents a final result.
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && adv) |=> (out_valid_r && out_r.last))
    else $error("closing step left no final result");

  // The stage moves only on a temperature event.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_EVENT) |=> $stable(stage_r))
    else $error("stage changed outside a temperature event");

  // A held grant exists only while a dispatch is being arbitrated.
  a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r == ST_GRANT || state_r == ST_FLUSH))
    else $error("held grant outside dispatch");

endmodule
`default_nettype wire

### sim/arbiter_grant_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts the results of every
// accepted request and compares each accepted result with the oldest prediction.
module arbiter_grant_checker
  import tswqa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tswqa_in_if                   in_ch,
  tswqa_out_if                  out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    grants_owed
);

  // Burst cap and credit reload ratio per stage, cool to critical.
  localparam int BURST_CAP     [4] = '{16, 8, 4, 2};
  localparam int FAST_RELOAD   [4] = '{5, 7, 3, 1};
  localparam int NORMAL_RELOAD [4] = '{3, 3, 1, 0};

  logic signed [8:0] zone_filter;
  logic [63:0]       guard_ns;
  logic signed [8:0] limit_c [8];

  stage_t      stage;
  logic [2:0]  cr_fast;
  logic [2:0]  cr_normal;
  logic [63:0] last_normal_ns;

  result_t grants_due [$];

  // Threshold register in millidegrees.
  function automatic longint limit_mc(cfg_reg_t r);
    return longint'(limit_c[r]) * 1000;
  endfunction

  // Hysteresis: the stage moves at most one level per event.
  function automatic stage_t stage_after(stage_t cur, longint t);
    case (cur)
      STAGE_COOL: begin
        return (t >= limit_mc(REG_RISE_WARM)) ? STAGE_WARM : STAGE_COOL;
      end
      STAGE_WARM: begin
        if (t >= limit_mc(REG_RISE_HOT)) return STAGE_HOT;
        if (t < limit_mc(REG_FALL_COOL)) return STAGE_COOL;
        return STAGE_WARM;
      end
      STAGE_HOT: begin
        if (t >= limit_mc(REG_RISE_CRIT)) return STAGE_CRIT;
        if (t < limit_mc(REG_FALL_WARM)) return STAGE_WARM;
        return STAGE_HOT;
      end
      default: begin
        return (t < limit_mc(REG_FALL_HOT)) ? STAGE_HOT : STAGE_CRIT;
      end
    endcase
  endfunction

  // A queue cannot be served when it has no credit or no entries.
  function automatic logic queue_blocked(logic q, int fcnt, int ncnt);
    if (q == QUEUE_NORMAL) return (cr_normal == 0) || (ncnt == 0);
    return (cr_fast == 0) || (fcnt == 0);
  endfunction

  // Works out the results of one request and queues them.
  task automatic predict_grants(input logic cmd, input logic [7:0] zone,
                                input logic signed [31:0] temp,
                                input logic [15:0] slots, input logic [15:0] fast_n,
                                input logic [15:0] normal_n, input logic [63:0] now);
    result_t r;
    stage_t  nxt;
    int      n;
    int      budget;
    int      fcnt;
    int      ncnt;
    logic    guard_hit;
    logic    halt;
    logic    pick;

    r = '0;
    if (cmd == CMD_TEMP) begin
      if (zone_filter < 0 || int'(zone) == int'(zone_filter)) begin
        nxt = stage_after(stage, longint'(temp));
        if (nxt != stage) begin
          stage = nxt;
          cr_fast = '0;
          cr_normal = '0;
        end
      end
      r.stage_now = stage;
      r.last = 1'b1;
      grants_due.push_back(r);
      return;
    end

    n = 0;
    fcnt = int'(fast_n);
    ncnt = int'(normal_n);
    halt = 1'b0;
    if (slots != 0) begin
      budget = BURST_CAP[stage];
      if (int'(slots) < budget) budget = int'(slots);
      if (MAX_GRANTS < budget) budget = MAX_GRANTS;

      // The starvation guard looks at the wrapping time difference.
      guard_hit = (ncnt > 0) && (now - last_normal_ns >= guard_ns);
      if (guard_hit) last_normal_ns = now;

      while (n < budget && !halt) begin
        if (cr_fast == 0 && cr_normal == 0) begin
          cr_fast = 3'(FAST_RELOAD[stage]);
          cr_normal = 3'(NORMAL_RELOAD[stage]);
        end
        if (guard_hit && n == 0) begin
          ncnt--;
          if (cr_normal != 0) cr_normal--;
          r = '{granted: 1'b1, queue_sel: QUEUE_NORMAL, forced: 1'b1,
                stage_now: stage, last: 1'b0};
          grants_due.push_back(r);
          n++;
        end else begin
          pick = (cr_fast >= cr_normal) ? QUEUE_FAST : QUEUE_NORMAL;
          if (queue_blocked(pick, fcnt, ncnt)) pick = ~pick;
          if (queue_blocked(pick, fcnt, ncnt)) begin
            halt = 1'b1;
          end else begin
            if (pick == QUEUE_NORMAL) begin
              ncnt--;
              cr_normal--;
            end else begin
              fcnt--;
              cr_fast--;
            end
            r = '{granted: 1'b1, queue_sel: pick, forced: 1'b0,
                  stage_now: stage, last: 1'b0};
            grants_due.push_back(r);
            n++;
          end
        end
      end
    end

    if (n == 0) begin
      r = '0;
      r.stage_now = stage;
      grants_due.push_back(r);
    end
    r = grants_due.pop_back();
    r.last = 1'b1;
    grants_due.push_back(r);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Results are compared before a request of the same edge is predicted, since
  // a result always belongs to an earlier request.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      zone_filter = RST_ZONE_FILTER;
      guard_ns = RST_GUARD_NS;
      limit_c[REG_RISE_WARM] = RST_RISE_WARM;
      limit_c[REG_RISE_HOT] = RST_RISE_HOT;
      limit_c[REG_RISE_CRIT] = RST_RISE_CRIT;
      limit_c[REG_FALL_COOL] = RST_FALL_COOL;
      limit_c[REG_FALL_WARM] = RST_FALL_WARM;
      limit_c[REG_FALL_HOT] = RST_FALL_HOT;
      stage = STAGE_COOL;
      cr_fast = '0;
      cr_normal = '0;
      last_normal_ns = '0;
      grants_due.delete();
      mismatches = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (grants_due.size() == 0) begin
          $error("result with no request outstanding: granted %0d queue_sel %0d",
                 out_ch.granted, out_ch.queue_sel);
          mismatches++;
        end else begin
          want = grants_due.pop_front();
          check_field("granted", want.granted, out_ch.granted);
          check_field("queue_sel", want.queue_sel, out_ch.queue_sel);
          check_field("forced", want.forced, out_ch.forced);
          check_field("stage_now", want.stage_now, out_ch.stage_now);
          check_field("last", want.last, out_ch.last);
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        predict_grants(in_ch.cmd, in_ch.zone_id, in_ch.temp_mc, in_ch.free_slots,
                       in_ch.fast_count, in_ch.normal_count, in_ch.time_ns);
      end

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_ZONE_FILTER: zone_filter = cfg_data[8:0];
          REG_GUARD_NS:    guard_ns = cfg_data;
          default:         limit_c[cfg_idx] = cfg_data[8:0];
        endcase
      end
    end
    grants_owed = grants_due.size();
  end

endmodule

### sim/thermal_staged_weighted_queue_arbiter_tb.sv
`timescale 1ns / 100ps

// Drives requests and register writes into the arbiter, applies random
// backpressure on the result side and reports the verdict.
module thermal_staged_weighted_queue_arbiter_tb;
  import tswqa_pkg::*;

  // Longest stretch without any accepted request or result.
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 5;
  localparam int PHASE_REQUESTS = 85;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         zone;
    logic signed [31:0] temp;
    logic [15:0]        slots;
    logic [15:0]        fast_n;
    logic [15:0]        normal_n;
    logic [63:0]        now;
  } request_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    grants_owed;
  int                    idle_cycles;
  int                    hold_left;
  logic                  calm;
  logic [63:0]           now_ns;
  int                    reg_deg [8];

  tswqa_in_if  in_ch ();
  tswqa_out_if out_ch ();

  thermal_staged_weighted_queue_arbiter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  arbiter_grant_checker grant_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .grants_owed (grants_owed)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Idle length: mostly none or short, now and then long.
  function automatic int pause_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Queue occupancy: mostly small so that queues run dry within a burst.
  function automatic logic [15:0] pick_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 65) return 16'($urandom_range(1, 8));
    return 16'($urandom);
  endfunction

  function automatic request_t noise_request();
    request_t r;
    r.cmd = 1'($urandom);
    r.zone = 8'($urandom);
    r.temp = $urandom;
    r.slots = 16'($urandom);
    r.fast_n = 16'($urandom);
    r.normal_n = 16'($urandom);
    r.now = {$urandom, $urandom};
    return r;
  endfunction

  function automatic request_t temp_request(logic [7:0] zone, logic signed [31:0] temp);
    request_t r;
    r = noise_request();
    r.cmd = CMD_TEMP;
    r.zone = zone;
    r.temp = temp;
    return r;
  endfunction

  function automatic request_t dispatch_request(logic [15:0] slots, logic [15:0] fast_n,
                                                logic [15:0] normal_n, logic [63:0] now);
    request_t r;
    r = noise_request();
    r.cmd = CMD_DISPATCH;
    r.slots = slots;
    r.fast_n = fast_n;
    r.normal_n = normal_n;
    r.now = now;
    now_ns = now;
    return r;
  endfunction

  // Temperatures cluster around the programmed thresholds; time mostly runs forward.
  function automatic request_t random_request();
    request_t r;
    cfg_reg_t lim;
    int       roll;
    r = noise_request();
    if ($urandom_range(0, 99) < 30) begin
      r.cmd = CMD_TEMP;
      if (reg_deg[REG_ZONE_FILTER] >= 0 && $urandom_range(0, 1) == 1) begin
        r.zone = 8'(reg_deg[REG_ZONE_FILTER]);
      end
      if ($urandom_range(0, 99) >= 15) begin
        lim = cfg_reg_t'($urandom_range(REG_RISE_WARM, REG_FALL_HOT));
        r.temp = 32'(reg_deg[lim] * 1000 + int'($urandom_range(0, 6000)) - 3000);
      end
    end else begin
      r.cmd = CMD_DISPATCH;
      roll = $urandom_range(0, 99);
      if (roll < 15) r.slots = '0;
      else if (roll < 75) r.slots = 16'($urandom_range(1, 20));
      r.fast_n = pick_count();
      r.normal_n = pick_count();
      roll = $urandom_range(0, 99);
      if (roll < 40) now_ns = now_ns + 64'($urandom_range(0, 2000));
      else if (roll < 80) now_ns = now_ns + {$urandom_range(0, 3), $urandom};
      else if (roll < 90) now_ns = {$urandom, $urandom};
      r.now = now_ns;
    end
    return r;
  endfunction

  // Presents one request and returns at the falling edge after it is accepted,
  // with valid still high.
  task automatic send_request(input request_t r);
    int gap;
    gap = calm ? 0 : pause_len();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.cmd = r.cmd;
    in_ch.zone_id = r.zone;
    in_ch.temp_mc = r.temp;
    in_ch.free_slots = r.slots;
    in_ch.fast_count = r.fast_n;
    in_ch.normal_count = r.normal_n;
    in_ch.time_ns = r.now;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds off new requests until every predicted result has come back.
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (grants_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [63:0] v);
    cfg_we = 1'b1;
    cfg_idx = r;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    if (r != REG_GUARD_NS) reg_deg[r] = int'($signed(v[8:0]));
  endtask

  task automatic set_thresholds(input int rw, input int rh, input int rc,
                                input int fc, input int fw, input int fh);
    write_reg(REG_RISE_WARM, 64'(longint'(rw)));
    write_reg(REG_RISE_HOT, 64'(longint'(rh)));
    write_reg(REG_RISE_CRIT, 64'(longint'(rc)));
    write_reg(REG_FALL_COOL, 64'(longint'(fc)));
    write_reg(REG_FALL_WARM, 64'(longint'(fw)));
    write_reg(REG_FALL_HOT, 64'(longint'(fh)));
  endtask

  // Result side backpressure.
  initial begin
    out_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (!calm && $urandom_range(0, 99) < 30) hold_left = pause_len();
      end
    end
  end

  // Watchdog on handshake progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("thermal_staged_weighted_queue_arbiter regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int p;
    int k;
    int deg [6];

    rst_n = 1'b0;
    calm = 1'b0;
    idle_cycles = 0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_TEMP;
    in_ch.zone_id = '0;
    in_ch.temp_mc = '0;
    in_ch.free_slots = '0;
    in_ch.fast_count = '0;
    in_ch.normal_count = '0;
    in_ch.time_ns = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_ZONE_FILTER;
    cfg_data = '0;
    now_ns = '0;
    reg_deg[REG_ZONE_FILTER] = -1;
    reg_deg[REG_GUARD_NS] = 0;
    reg_deg[REG_RISE_WARM] = 67;
    reg_deg[REG_RISE_HOT] = 72;
    reg_deg[REG_RISE_CRIT] = 77;
    reg_deg[REG_FALL_COOL] = 64;
    reg_deg[REG_FALL_WARM] = 69;
    reg_deg[REG_FALL_HOT] = 74;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed requests on the reset settings.
    send_request(dispatch_request(16'd0, 16'd5, 16'd5, 64'd9_000_000_000));
    send_request(dispatch_request(16'd4, 16'd0, 16'd0, 64'd0));
    send_request(dispatch_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 64'd0));
    send_request(dispatch_request(16'd3, 16'd2, 16'd9, 64'd5_000_000_000));
    send_request(dispatch_request(16'd8, 16'd0, 16'd3, 64'd5_000_000_001));
    send_request(dispatch_request(16'd8, 16'd6, 16'd0, 64'd5_000_000_002));
    send_request(temp_request(8'd0, 32'sd66999));
    send_request(temp_request(8'd255, 32'sd67000));
    send_request(dispatch_request(16'hFFFF, 16'd20, 16'd20, 64'd6_000_000_000));
    send_request(temp_request(8'd3, 32'sd72000));
    send_request(dispatch_request(16'd10, 16'd10, 16'd10, 64'd12_000_000_000));
    send_request(temp_request(8'd7, 32'sd77000));
    send_request(dispatch_request(16'd5, 16'd5, 16'd5, 64'd12_000_000_100));
    send_request(dispatch_request(16'd2, 16'd0, 16'd4, 64'd18_000_000_000));
    send_request(dispatch_request(16'd2, 16'd0, 16'd4, 64'd18_000_000_001));
    send_request(temp_request(8'd1, 32'sh7FFF_FFFF));
    send_request(temp_request(8'd1, 32'sd73999));
    send_request(temp_request(8'd1, 32'sh8000_0000));
    send_request(temp_request(8'd1, 32'sd63999));
    send_request(dispatch_request(16'd1, 16'd1, 16'd1, 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(dispatch_request(16'd3, 16'd1, 16'd1, 64'd100));

    // Only one zone counts once the filter is set.
    wait_idle();
    write_reg(REG_ZONE_FILTER, 64'd5);
    send_request(temp_request(8'd4, 32'sd100000));
    send_request(temp_request(8'd5, 32'sd100000));
    send_request(temp_request(8'd5, 32'sd0));
    send_request(dispatch_request(16'hFFFF, 16'hFFFF, 16'd0, 64'hFFFF_FFFF_FFFF_FFFE));

    // Random requests under several register settings.
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(REG_ZONE_FILTER, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(REG_GUARD_NS, 64'd0);
          set_thresholds(67, 72, 77, 64, 69, 74);
        end
        1: begin
          write_reg(REG_ZONE_FILTER, 64'd255);
          write_reg(REG_GUARD_NS, 64'hFFFF_FFFF_FFFF_FFFF);
          set_thresholds(-40, -40, -40, 150, 150, 150);
        end
        2: begin
          write_reg(REG_ZONE_FILTER, 64'd0);
          write_reg(REG_GUARD_NS, 64'd1000);
          set_thresholds(150, 150, 150, -40, -40, -40);
        end
        3: begin
          write_reg(REG_ZONE_FILTER, 64'(longint'(int'($urandom_range(0, 256)) - 1)));
          write_reg(REG_GUARD_NS, {$urandom_range(0, 3), $urandom});
          foreach (deg[i]) deg[i] = int'($urandom_range(0, 190)) - 40;
          set_thresholds(deg[0], deg[1], deg[2], deg[3], deg[4], deg[5]);
        end
        default: begin
          write_reg(REG_ZONE_FILTER, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(REG_GUARD_NS, 64'd5_000_000_000);
          set_thresholds(10, 20, 30, 5, 15, 25);
        end
      endcase

      // Each phase opens back to back on both sides, then idles at random.
      calm = 1'b1;
      for (k = 0; k < PHASE_REQUESTS; k++) begin
        if (k == 20) calm = 1'b0;
        if (k == 60) wait_idle();
        send_request(random_request());
      end
      calm = 1'b0;
    end

    wait_idle();
    repeat (30) @(negedge clk);
    if (mismatches == 0) begin
      $display("thermal_staged_weighted_queue_arbiter regression: pass");
    end else begin
      $display("thermal_staged_weighted_queue_arbiter regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/tswqa_pkg.sv
hw/rtl/tswqa_in_if.sv
hw/rtl/tswqa_out_if.sv
hw/rtl/tswqa_cfg_regs.sv
hw/rtl/tswqa_thermal.sv
hw/rtl/tswqa_credit_unit.sv
hw/rtl/thermal_staged_weighted_queue_arbiter.sv
sim/arbiter_grant_checker.sv
sim/thermal_staged_weighted_queue_arbiter_tb.sv
